FILE: src/fbpfl_pkg.sv
// ----------------------------------------------------------------------------
// fbpfl_pkg
// Shared types and constants for the fixed block pool free list.
// ----------------------------------------------------------------------------
package fbpfl_pkg;

   localparam int NUM_BLOCKS_DEFAULT = 256;

   localparam int OFFSET_W     = 24;
   localparam int STATUS_W     = 2;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 9;
   localparam int BLOCKS_W     = 9;
   localparam int LOG2_W       = 5;

   localparam logic [BLOCKS_W-1:0] BLOCKS_RESET = 9'd256;
   localparam logic [LOG2_W-1:0]   LOG2_RESET   = 5'd6;
   localparam logic [LOG2_W-1:0]   LOG2_MIN     = 5'd3;
   localparam logic [LOG2_W-1:0]   LOG2_MAX     = 5'd16;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_OFFSET = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_BLOCKS_IN_USE    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_BYTES_LOG2 = 1'b1;

   typedef struct packed {
      logic sweep_clear;
      logic sweep_write;
      logic issue;
      logic exec;
   } dp_cmd_type;

   typedef struct packed {
      logic sweep_last;
   } dp_status_type;

endpackage

FILE: src/fbpfl_ctrl.sv
// ----------------------------------------------------------------------------
// fbpfl_ctrl
// Controller: link table initialization sweep, command issue and execute.
// ----------------------------------------------------------------------------
module fbpfl_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     cfg_we,
   input  fbpfl_pkg::dp_status_type dp_status,
   output fbpfl_pkg::dp_cmd_type    dp_cmd,
   output logic                     busy
);
   import fbpfl_pkg::*;

   localparam logic [1:0] ST_SWEEP = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      if (cfg_we) begin
         dp_cmd.sweep_clear = 1'b1;
         state_in           = ST_SWEEP;
      end else begin
         case (state_ff)
            ST_SWEEP: begin
               dp_cmd.sweep_write = 1'b1;
               if (dp_status.sweep_last) begin
                  state_in = ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  dp_cmd.issue = 1'b1;
                  state_in     = ST_RUN;
               end
            end
            ST_RUN: begin
               dp_cmd.exec = 1'b1;
               state_in    = ST_IDLE;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: src/fbpfl_dp.sv
// ----------------------------------------------------------------------------
// fbpfl_dp
// Datapath: link memory, free list head, config registers, offset math.
// ----------------------------------------------------------------------------
module fbpfl_dp #(
   parameter int NUM_BLOCKS = fbpfl_pkg::NUM_BLOCKS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fbpfl_pkg::dp_cmd_type               dp_cmd,
   output fbpfl_pkg::dp_status_type            dp_status,
   input  logic                                cfg_we,
   input  logic [fbpfl_pkg::CSR_INDEX_W-1:0]   cfg_index,
   input  logic [fbpfl_pkg::CSR_DATA_W-1:0]    cfg_wdata,
   input  logic                                req_cmd,
   input  logic [fbpfl_pkg::OFFSET_W-1:0]      req_free_offset,
   output logic                                rsp_strobe,
   output logic [fbpfl_pkg::STATUS_W-1:0]      rsp_status,
   output logic [fbpfl_pkg::OFFSET_W-1:0]      rsp_block_offset
);
   import fbpfl_pkg::*;

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int CMP_W = (CNT_W > BLOCKS_W) ? CNT_W : BLOCKS_W;

   // entry = {valid, link}
   logic [IDX_W:0] link_mem [NUM_BLOCKS];

   logic [BLOCKS_W-1:0] blocks_ff, blocks_in;
   logic [LOG2_W-1:0]   log2_ff, log2_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic                head_valid_ff, head_valid_in;
   logic [IDX_W-1:0]    sweep_ff, sweep_in;
   logic                op_ff, op_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [IDX_W:0]      rd_ff;
   logic                strobe_ff, strobe_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [OFFSET_W-1:0] blk_off_ff, blk_off_in;

   logic [CMP_W-1:0]    count_wide;
   logic [CNT_W-1:0]    count;
   logic [LOG2_W-1:0]   shift;
   logic [OFFSET_W-1:0] low_mask;
   logic [OFFSET_W-1:0] free_idx;
   logic                free_bad;
   logic [OFFSET_W-1:0] alloc_offset;
   logic [CNT_W-1:0]    sweep_next;
   logic [IDX_W:0]      chain_entry;

   logic                mem_we;
   logic [IDX_W-1:0]    mem_addr;
   logic [IDX_W:0]      mem_data;

   always_comb begin
      if (blocks_ff == '0) begin
         count_wide = CMP_W'(1);
      end else if (CMP_W'(blocks_ff) > CMP_W'(NUM_BLOCKS)) begin
         count_wide = CMP_W'(NUM_BLOCKS);
      end else begin
         count_wide = CMP_W'(blocks_ff);
      end
      count = count_wide[CNT_W-1:0];

      if (log2_ff < LOG2_MIN) begin
         shift = LOG2_MIN;
      end else if (log2_ff > LOG2_MAX) begin
         shift = LOG2_MAX;
      end else begin
         shift = log2_ff;
      end
   end

   assign low_mask     = (OFFSET_W'(1) << shift) - OFFSET_W'(1);
   assign free_idx     = offset_ff >> shift;
   assign free_bad     = ((offset_ff & low_mask) != '0) || (free_idx >= OFFSET_W'(count));
   assign alloc_offset = OFFSET_W'(head_ff) << shift;
   assign sweep_next   = CNT_W'(sweep_ff) + CNT_W'(1);
   assign chain_entry  = (sweep_next < count) ? {1'b1, sweep_next[IDX_W-1:0]} : '0;

   assign dp_status.sweep_last = (sweep_ff == IDX_W'(NUM_BLOCKS - 1));

   always_comb begin
      blocks_in     = blocks_ff;
      log2_in       = log2_ff;
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      sweep_in      = sweep_ff;
      op_in         = op_ff;
      offset_in     = offset_ff;
      strobe_in     = 1'b0;
      status_in     = status_ff;
      blk_off_in    = blk_off_ff;
      mem_we        = 1'b0;
      mem_addr      = sweep_ff;
      mem_data      = chain_entry;

      if (cfg_we) begin
         case (cfg_index)
            REG_BLOCKS_IN_USE:    blocks_in = cfg_wdata[BLOCKS_W-1:0];
            REG_BLOCK_BYTES_LOG2: log2_in   = cfg_wdata[LOG2_W-1:0];
            default:              blocks_in = blocks_ff;
         endcase
      end

      if (dp_cmd.sweep_clear) begin
         sweep_in      = '0;
         head_in       = '0;
         head_valid_in = 1'b1;
      end else if (dp_cmd.sweep_write) begin
         mem_we   = 1'b1;
         sweep_in = sweep_ff + IDX_W'(1);
      end

      if (dp_cmd.issue) begin
         op_in     = req_cmd;
         offset_in = req_free_offset;
      end

      if (dp_cmd.exec) begin
         strobe_in  = 1'b1;
         blk_off_in = '0;
         if (op_ff == CMD_ALLOC) begin
            if (head_valid_ff) begin
               status_in     = STATUS_OK;
               blk_off_in    = alloc_offset;
               head_in       = rd_ff[IDX_W-1:0];
               head_valid_in = rd_ff[IDX_W];
            end else begin
               status_in = STATUS_EMPTY;
            end
         end else begin
            if (free_bad) begin
               status_in = STATUS_BAD_OFFSET;
            end else begin
               status_in     = STATUS_OK;
               mem_we        = 1'b1;
               mem_addr      = free_idx[IDX_W-1:0];
               mem_data      = {head_valid_ff, head_ff};
               head_in       = free_idx[IDX_W-1:0];
               head_valid_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_addr] <= mem_data;
      end
      if (dp_cmd.issue) begin
         rd_ff <= link_mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_ff     <= BLOCKS_RESET;
         log2_ff       <= LOG2_RESET;
         head_ff       <= '0;
         head_valid_ff <= 1'b1;
         sweep_ff      <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         blocks_ff     <= blocks_in;
         log2_ff       <= log2_in;
         head_ff       <= head_in;
         head_valid_ff <= head_valid_in;
         sweep_ff      <= sweep_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      offset_ff  <= offset_in;
      status_ff  <= status_in;
      blk_off_ff <= blk_off_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_block_offset = blk_off_ff;

endmodule

FILE: src/fixed_block_pool_free_list.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_free_list
// LIFO free list allocator for a pool of equal-sized blocks.
//
//   channel   handshake                 payload
//   request   start, busy               req_cmd, req_free_offset
//   response  rsp_strobe (one cycle)    rsp_status, rsp_block_offset
//   csr       csr_valid, csr_ready      csr_index, csr_wdata
//
// Each transaction is accepted in IDLE and then executed in the RUN state,
// which uses the registered read of the head's link; the response strobes the
// cycle after, when a new request can already be accepted.
// After reset and after every csr write the link memory is rebuilt, one
// entry per cycle, with busy high. csr_ready is always high.
// The response cannot be stalled.
// ----------------------------------------------------------------------------
module fixed_block_pool_free_list #(
   parameter int NUM_BLOCKS = fbpfl_pkg::NUM_BLOCKS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_cmd,
   input  logic [fbpfl_pkg::OFFSET_W-1:0]      req_free_offset,
   output logic                                rsp_strobe,
   output logic [fbpfl_pkg::STATUS_W-1:0]      rsp_status,
   output logic [fbpfl_pkg::OFFSET_W-1:0]      rsp_block_offset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fbpfl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fbpfl_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import fbpfl_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   logic          cfg_we;

   assign csr_ready = 1'b1;
   assign cfg_we    = csr_valid & csr_ready;

   fbpfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cfg_we    (cfg_we),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd),
      .busy      (busy)
   );

   fbpfl_dp #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .cfg_we           (cfg_we),
      .cfg_index        (csr_index),
      .cfg_wdata        (csr_wdata),
      .req_cmd          (req_cmd),
      .req_free_offset  (req_free_offset),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_block_offset (rsp_block_offset)
   );

   a_rsp_follows_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("response without a request two cycles earlier");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !cfg_we) |=> busy)
      else $error("busy not raised after accept");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe longer than one cycle");

   a_offset_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != STATUS_OK) |-> (rsp_block_offset == '0))
      else $error("nonzero offset on failed transaction");

endmodule
